>>> design/tns_pkg.sv
// Shared types and constants for the tone note sequencer.
`timescale 1ns / 1ps

package tns_pkg;

    localparam int ADDR_W             = 8;
    localparam int ADDR_SPAN          = 2 ** ADDR_W;
    localparam int FREQ_W             = 16;
    localparam int DUR_W              = 16;
    localparam int TIME_W             = DUR_W + 1;
    localparam int PERIOD_W           = 8;
    localparam int NOTE_DEPTH_DEFAULT = 256;

    localparam logic [PERIOD_W-1:0] TICK_PERIOD_RESET = PERIOD_W'(4);

    typedef enum logic [1:0] {
        ACT_TICK  = 2'd0,
        ACT_WRITE = 2'd1,
        ACT_START = 2'd2,
        ACT_STOP  = 2'd3
    } action_t;

    typedef struct packed {
        action_t             action;
        logic [ADDR_W-1:0]   entry_address;
        logic [FREQ_W-1:0]   note_frequency;
        logic [DUR_W-1:0]    note_duration;
    } item_t;

    typedef struct packed {
        logic [FREQ_W-1:0]   tone_frequency;
        logic                pin_attached;
        logic                tune_done;
        logic [ADDR_W-1:0]   current_entry;
    } result_t;

    // One stored note: duration in the upper half, frequency in the lower.
    typedef struct packed {
        logic [DUR_W-1:0]    duration;
        logic [FREQ_W-1:0]   frequency;
    } note_entry_t;

endpackage

>>> design/tns_note_store.sv
// Note memory: one write port, one read port with registered data.
`timescale 1ns / 1ps

module tns_note_store
    import tns_pkg::*;
#(
    parameter int NOTE_DEPTH = NOTE_DEPTH_DEFAULT,
    localparam int IW        = $clog2(NOTE_DEPTH)
)
(
    input  logic          clk,
    input  logic          wr_en,
    input  logic [IW-1:0] wr_addr,
    input  note_entry_t   wr_data,
    input  logic          rd_en,
    input  logic [IW-1:0] rd_addr,
    output note_entry_t   rd_data
);

    note_entry_t mem [NOTE_DEPTH];
    note_entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> design/tone_note_sequencer.sv
// Top level of the tone note sequencer: control, timing and result register.
`timescale 1ns / 1ps
//
//  channel   direction  handshake            payload
//  item      in         item_valid/stall     item_data (item_t)
//  result    out        res_valid/res_stall  res_data (result_t)
//  cfg       in         cfg_valid/cfg_ready  cfg_data (tick period, ms)
//
// One item per cycle sustained while res_stall is low; each item's result is loaded
// into the result register from the stage (note memory read and stage loaded on the
// transfer edge, state update into the result register when the stage advances).
// The note memory is written on the transfer edge of a write item; the read
// for a start or a tick is issued on its transfer edge, a start addressed by its
// own entry, a tick from the state the item ahead of it leaves, so no bubble is needed.
// rst_n clears playback state and the tick period (4 ms); note contents are
// undefined until written. A stalled result holds the stage, which stalls
// the item channel; cfg_ready is always high.

module tone_note_sequencer
    import tns_pkg::*;
#(
    parameter int NOTE_DEPTH = NOTE_DEPTH_DEFAULT
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_stall,
    input  item_t               item_data,
    output logic                res_valid,
    input  logic                res_stall,
    output result_t             res_data,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [PERIOD_W-1:0] cfg_data
);

    localparam int IW = $clog2(NOTE_DEPTH);
    localparam logic [IW-1:0] LAST_INDEX = IW'(NOTE_DEPTH - 1);

    // Entry address wrap table: address modulo the memory depth.
    logic [IW-1:0] addr_wrap [ADDR_SPAN];

    for (genvar g = 0; g < ADDR_SPAN; g++)
    begin : g_wrap
        assign addr_wrap[g] = IW'(g % NOTE_DEPTH);
    end

    // Playback state
    logic                       playing_reg,  playing_next;
    logic [IW-1:0]              index_reg,    index_next;
    logic signed [TIME_W-1:0]   time_reg,     time_next;
    logic [FREQ_W-1:0]          freq_reg,     freq_next;
    logic [PERIOD_W-1:0]        period_reg;
    logic                       done_next;

    // Stage between transfer and result
    logic                       stage_valid_reg;
    action_t                    stage_action_reg;
    logic [IW-1:0]              stage_index_reg;

    logic                       res_valid_reg;
    result_t                    res_data_reg;

    logic                       advance;
    logic                       item_take;
    logic [IW-1:0]              item_index;
    logic [IW-1:0]              eff_index;
    logic [IW-1:0]              rd_addr;
    note_entry_t                entry;
    logic                       end_marker;
    logic signed [TIME_W-1:0]   time_sub;

    function automatic logic [IW-1:0] next_index(input logic [IW-1:0] idx);
        next_index = (idx == LAST_INDEX) ? '0 : idx + IW'(1);
    endfunction

    // Handshakes
    assign advance    = stage_valid_reg && (!res_valid_reg || !res_stall);
    assign item_stall = stage_valid_reg && !advance;
    assign item_take  = item_valid && !item_stall;
    assign cfg_ready  = 1'b1;

    assign item_index = addr_wrap[item_data.entry_address];

    // Read address for the incoming item: its own entry for a start, else from the state the staged item leaves.
    assign eff_index = stage_valid_reg ? index_next : index_reg;
    assign rd_addr   = (item_data.action == ACT_START) ? item_index
                                                       : next_index(eff_index);

    tns_note_store #(
        .NOTE_DEPTH (NOTE_DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (item_take && item_data.action == ACT_WRITE),
        .wr_addr (item_index),
        .wr_data ('{duration: item_data.note_duration,
                    frequency: item_data.note_frequency}),
        .rd_en   (item_take),
        .rd_addr (rd_addr),
        .rd_data (entry)
    );

    assign end_marker = (entry.frequency == '0) && (entry.duration == '0);

    // Remaining time drops only while positive.
    assign time_sub = (time_reg > 0)
                    ? time_reg - $signed({{(TIME_W-PERIOD_W){1'b0}}, period_reg})
                    : time_reg;

    always_comb
    begin
        playing_next = playing_reg;
        index_next   = index_reg;
        time_next    = time_reg;
        freq_next    = freq_reg;
        done_next    = 1'b0;
        unique case (stage_action_reg)
            ACT_TICK:
            begin
                if (playing_reg)
                begin
                    time_next = time_sub;
                    if (time_sub <= 0)
                    begin
                        index_next = next_index(index_reg);
                        if (end_marker)
                        begin
                            freq_next    = '0;
                            playing_next = 1'b0;
                            done_next    = 1'b1;
                        end
                        else
                        begin
                            freq_next = entry.frequency;
                            time_next = $signed({1'b0, entry.duration});
                        end
                    end
                end
            end
            ACT_WRITE:
            begin
                // entry already stored on transfer
            end
            ACT_START:
            begin
                index_next   = stage_index_reg;
                playing_next = 1'b1;
                if (end_marker)
                begin
                    freq_next    = '0;
                    playing_next = 1'b0;
                    done_next    = 1'b1;
                end
                else
                begin
                    freq_next = entry.frequency;
                    time_next = $signed({1'b0, entry.duration});
                end
            end
            ACT_STOP:
            begin
                playing_next = 1'b0;
                freq_next    = '0;
            end
            default:
            begin
                playing_next = playing_reg;
            end
        endcase
    end

    // Control and state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
            res_valid_reg   <= 1'b0;
            playing_reg     <= 1'b0;
            index_reg       <= '0;
            time_reg        <= '0;
            freq_reg        <= '0;
            period_reg      <= TICK_PERIOD_RESET;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                period_reg <= cfg_data;
            end
            if (item_take)
            begin
                stage_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                stage_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                res_valid_reg <= 1'b1;
                playing_reg   <= playing_next;
                index_reg     <= index_next;
                time_reg      <= time_next;
                freq_reg      <= freq_next;
            end
            else if (!res_stall)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (item_take)
        begin
            stage_action_reg <= item_data.action;
            stage_index_reg  <= item_index;
        end
        if (advance)
        begin
            res_data_reg.tone_frequency <= freq_next;
            res_data_reg.pin_attached   <= playing_next;
            res_data_reg.tune_done      <= done_next;
            res_data_reg.current_entry  <= ADDR_W'(index_next);
        end
    end

    assign res_valid = res_valid_reg;
    assign res_data  = res_data_reg;

endmodule
